// ===== rtl/fbik_pkg.sv =====
// ----------------------------------------------------------------------------
// fbik_pkg
// shared widths, cordic table, sideband structs and register indexes
// ----------------------------------------------------------------------------
package fbik_pkg;

  localparam int LEN_W   = 23;   // arm lengths, unsigned
  localparam int COORD_W = 24;   // target coordinates, signed
  localparam int OFF_W   = 25;   // x measured from a motor axis, signed
  localparam int LAY_W   = 49;   // 2*la*y, signed
  localparam int WIDE_W  = 52;   // discriminant factors, numerator, denominator
  localparam int MAG_W   = 50;   // magnitude of a discriminant factor
  localparam int HALF_W  = MAG_W / 2;
  localparam int RAD_W   = 2 * MAG_W;
  localparam int ROOT_W  = RAD_W / 2;
  localparam int NORM_W  = 60;   // normalized magnitude lands in [2^59, 2^60)
  localparam int CW      = 64;   // cordic x/y datapath
  localparam int Z_W     = 33;   // cordic angle accumulator, q30
  localparam int CORDIC_STEPS = 31;
  localparam int NORM_STEPS   = 6;

  localparam logic [31:0] PI_Q30 = 32'd3373259426;

  localparam logic [31:0] ATAN_Q30 [CORDIC_STEPS] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
    32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
    32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
    32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
    32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
    32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
    32'h00000001
  };

  typedef enum logic [1:0] {
    CFG_BASE_ARM      = 2'd0,
    CFG_LINK_ARM      = 2'd1,
    CFG_MOTOR_SPACING = 2'd2
  } cfg_idx_e;

  // carried alongside the square root
  typedef struct packed {
    logic signed [WIDE_W-1:0] den;
    logic signed [LAY_W-1:0]  lay2;
    logic                     ok;
    logic                     ws;
  } sq_side_t;

  // carried alongside the arctangent
  typedef struct packed {
    logic dz;      // denominator is zero
    logic npos;    // numerator > 0
    logic nzero;   // numerator == 0
    logic ok;
    logic ws;
  } cd_side_t;

  // per motor status toward the top level
  typedef struct packed {
    logic ok;
    logic ws;
  } solve_flags_t;

endpackage

// ===== rtl/five_bar_inverse_kinematics_unit.sv =====
// ----------------------------------------------------------------------------
// five_bar_inverse_kinematics_unit
// stages: 1 input register and 98 solver stages, of which 50 are the square
//   root and 38 the arctangent
// throughput: one item per cycle; a two entry output buffer decouples the
//   pipeline from the output side, so the pipeline stalls only when it is full
// reset: asynchronous active low; valid bits and buffer clear, registers load
//   their default arm lengths and motor spacing
// ----------------------------------------------------------------------------
module five_bar_inverse_kinematics_unit #(
  parameter int ANGLE_FRAC_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // target item
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [47:0]                         s_axis_tdata,  // target_x, target_y
  // result item
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [((2*ANGLE_FRAC_BITS+13)/8)*8-1:0] m_axis_tdata, // left_angle, right_angle
  output logic [1:0]                          m_axis_tuser,  // in_workspace, solution_valid
  // configuration writes
  input  logic                                cfg_we_i,
  input  logic [1:0]                          cfg_idx_i,
  input  logic [fbik_pkg::LEN_W-1:0]          cfg_data_i
);
  import fbik_pkg::*;

  localparam int ANG_W = ANGLE_FRAC_BITS + 3;
  localparam int TD_W  = ((2 * ANG_W + 7) / 8) * 8;

  // configuration registers
  logic [LEN_W-1:0] la_q, lb_q, lc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      la_q <= LEN_W'(409600);
      lb_q <= LEN_W'(614400);
      lc_q <= LEN_W'(204800);
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_BASE_ARM:      la_q <= cfg_data_i;
        CFG_LINK_ARM:      lb_q <= cfg_data_i;
        CFG_MOTOR_SPACING: lc_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // pipeline advances whenever the output buffer has room for one more item
  logic       en;
  logic [1:0] cnt_q;

  assign en            = (cnt_q != 2'd2);
  assign s_axis_tready = en;

  // input register: target and its offset from the right motor axis
  logic signed [COORD_W-1:0] x_q, y_q;
  logic signed [OFF_W-1:0]   u_q;
  logic                      vin_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vin_q <= 1'b0;
    end else if (en) begin
      vin_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      x_q <= $signed(s_axis_tdata[COORD_W-1:0]);
      y_q <= $signed(s_axis_tdata[2*COORD_W-1:COORD_W]);
      u_q <= OFF_W'($signed(s_axis_tdata[COORD_W-1:0])) - OFF_W'($signed({1'b0, lc_q}));
    end
  end

  // left motor at the origin (positive branch), right motor at the spacing
  logic                    vl, vr;
  logic signed [ANG_W-1:0] ang_l, ang_r;
  solve_flags_t            flg_l, flg_r;

  fbik_solver #(
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
    .PLUS            (1'b1)
  ) u_left (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (vin_q),
    .u_i     (OFF_W'(x_q)),
    .y_i     (y_q),
    .la_i    (la_q),
    .lb_i    (lb_q),
    .valid_o (vl),
    .angle_o (ang_l),
    .flags_o (flg_l)
  );

  fbik_solver #(
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
    .PLUS            (1'b0)
  ) u_right (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (vin_q),
    .u_i     (u_q),
    .y_i     (y_q),
    .la_i    (la_q),
    .lb_i    (lb_q),
    .valid_o (vr),
    .angle_o (ang_r),
    .flags_o (flg_r)
  );

  // both solvers run in lockstep; angles read zero unless both are defined
  logic both_ok, push, pop;

  assign both_ok = flg_l.ok && flg_r.ok;
  assign push    = en && vl && vr;
  assign pop     = m_axis_tvalid && m_axis_tready;

  // two entry output buffer
  logic [ANG_W-1:0] bl_q [2];
  logic [ANG_W-1:0] br_q [2];
  logic             bws_q [2];
  logic             bok_q [2];
  logic             wr_q, rd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
    end else begin
      if (push) begin
        wr_q <= ~wr_q;
      end
      if (pop) begin
        rd_q <= ~rd_q;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      bl_q[wr_q]  <= both_ok ? ang_l : '0;
      br_q[wr_q]  <= both_ok ? ang_r : '0;
      bws_q[wr_q] <= flg_l.ws && flg_r.ws;
      bok_q[wr_q] <= both_ok;
    end
  end

  assign m_axis_tvalid = (cnt_q != 2'd0);
  assign m_axis_tdata  = TD_W'({br_q[rd_q], bl_q[rd_q]});
  assign m_axis_tuser  = {bok_q[rd_q], bws_q[rd_q]};

endmodule

// ===== rtl/fbik_isqrt.sv =====
// ----------------------------------------------------------------------------
// fbik_isqrt
// pipelined integer square root, one root bit per stage
// ----------------------------------------------------------------------------
module fbik_isqrt #(
  parameter int RAD_W  = 100,
  parameter int SIDE_W = 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  logic [RAD_W-1:0]     rad_i,
  input  logic [SIDE_W-1:0]    side_i,
  output logic                 valid_o,
  output logic [RAD_W/2-1:0]   root_o,
  output logic [SIDE_W-1:0]    side_o
);
  localparam int RT_W  = RAD_W / 2;
  localparam int REM_W = RT_W + 2;

  logic [RAD_W-1:0]  rad_q  [RT_W];
  logic [REM_W-1:0]  rem_q  [RT_W];
  logic [RT_W-1:0]   root_q [RT_W];
  logic [SIDE_W-1:0] side_q [RT_W];
  logic [RT_W-1:0]   v_q;

  for (genvar i = 0; i < RT_W; i++) begin : g_step
    logic [RAD_W-1:0]  cur_rad;
    logic [REM_W-1:0]  cur_rem;
    logic [RT_W-1:0]   cur_root;
    logic [SIDE_W-1:0] cur_side;
    logic              cur_v;
    logic [REM_W+1:0]  t, trial;
    logic              ge;

    if (i == 0) begin : g_first
      assign cur_rad  = rad_i;
      assign cur_rem  = '0;
      assign cur_root = '0;
      assign cur_side = side_i;
      assign cur_v    = valid_i;
    end else begin : g_next
      assign cur_rad  = rad_q[i-1];
      assign cur_rem  = rem_q[i-1];
      assign cur_root = root_q[i-1];
      assign cur_side = side_q[i-1];
      assign cur_v    = v_q[i-1];
    end

    // bring down two radicand bits, try root bit one
    assign t     = {cur_rem, cur_rad[RAD_W-1 -: 2]};
    assign trial = {2'b00, cur_root, 2'b01};
    assign ge    = (t >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i] <= 1'b0;
      end else if (en_i) begin
        v_q[i] <= cur_v;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rad_q[i]  <= {cur_rad[RAD_W-3:0], 2'b00};
        rem_q[i]  <= ge ? REM_W'(t - trial) : REM_W'(t);
        root_q[i] <= {cur_root[RT_W-2:0], ge};
        side_q[i] <= cur_side;
      end
    end
  end

  assign valid_o = v_q[RT_W-1];
  assign root_o  = root_q[RT_W-1];
  assign side_o  = side_q[RT_W-1];

endmodule

// ===== rtl/fbik_cordic.sv =====
// ----------------------------------------------------------------------------
// fbik_cordic
// pipelined arctangent: magnitude pick, staged normalize, cordic vectoring
// ----------------------------------------------------------------------------
module fbik_cordic #(
  parameter int SIDE_W = 1
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              valid_i,
  input  logic signed [fbik_pkg::WIDE_W-1:0] den_i,
  input  logic signed [fbik_pkg::WIDE_W-1:0] num_i,
  input  logic [SIDE_W-1:0]                 side_i,
  output logic                              valid_o,
  output logic signed [fbik_pkg::Z_W-1:0]    z_o,
  output logic [SIDE_W-1:0]                 side_o
);
  import fbik_pkg::*;

  // magnitude pick stage
  logic signed [WIDE_W-1:0] anum;
  logic [WIDE_W-1:0]        mag;
  logic signed [CW-1:0]     x0_q, y0_q;
  logic [NORM_W-1:0]        m0_q;
  logic [SIDE_W-1:0]        s0_q;
  logic                     v0_q;

  assign anum = (num_i < 0) ? -num_i : num_i;
  assign mag  = (den_i > anum) ? den_i : anum;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (en_i) begin
      v0_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x0_q <= CW'(den_i);
      y0_q <= CW'(num_i);
      m0_q <= NORM_W'(mag);
      s0_q <= side_i;
    end
  end

  // normalize: binary search shift by 32, 16, 8, 4, 2, 1
  logic signed [CW-1:0] nx_q [NORM_STEPS];
  logic signed [CW-1:0] ny_q [NORM_STEPS];
  logic [NORM_W-1:0]    nm_q [NORM_STEPS];
  logic [SIDE_W-1:0]    ns_q [NORM_STEPS];
  logic [NORM_STEPS-1:0] nv_q;

  for (genvar j = 0; j < NORM_STEPS; j++) begin : g_norm
    localparam int SH = 32 >> j;
    logic signed [CW-1:0] cx, cy;
    logic [NORM_W-1:0]    cm;
    logic [SIDE_W-1:0]    cs;
    logic                 cv, lead_zero;

    if (j == 0) begin : g_first
      assign cx = x0_q;
      assign cy = y0_q;
      assign cm = m0_q;
      assign cs = s0_q;
      assign cv = v0_q;
    end else begin : g_next
      assign cx = nx_q[j-1];
      assign cy = ny_q[j-1];
      assign cm = nm_q[j-1];
      assign cs = ns_q[j-1];
      assign cv = nv_q[j-1];
    end

    assign lead_zero = (cm[NORM_W-1 -: SH] == '0);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        nv_q[j] <= 1'b0;
      end else if (en_i) begin
        nv_q[j] <= cv;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        nx_q[j] <= lead_zero ? (cx <<< SH) : cx;
        ny_q[j] <= lead_zero ? (cy <<< SH) : cy;
        nm_q[j] <= lead_zero ? (cm << SH) : cm;
        ns_q[j] <= cs;
      end
    end
  end

  // vectoring iterations, one per stage
  logic signed [CW-1:0]  rx_q [CORDIC_STEPS];
  logic signed [CW-1:0]  ry_q [CORDIC_STEPS];
  logic signed [Z_W-1:0] rz_q [CORDIC_STEPS];
  logic [SIDE_W-1:0]     rs_q [CORDIC_STEPS];
  logic [CORDIC_STEPS-1:0] rv_q;

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
    logic signed [CW-1:0]  cx, cy, xs, ys;
    logic signed [Z_W-1:0] cz, step;
    logic [SIDE_W-1:0]     cs;
    logic                  cv;

    if (i == 0) begin : g_first
      assign cx = nx_q[NORM_STEPS-1];
      assign cy = ny_q[NORM_STEPS-1];
      assign cz = '0;
      assign cs = ns_q[NORM_STEPS-1];
      assign cv = nv_q[NORM_STEPS-1];
    end else begin : g_next
      assign cx = rx_q[i-1];
      assign cy = ry_q[i-1];
      assign cz = rz_q[i-1];
      assign cs = rs_q[i-1];
      assign cv = rv_q[i-1];
    end

    assign xs   = cx >>> i;
    assign ys   = cy >>> i;
    assign step = Z_W'($signed({1'b0, ATAN_Q30[i]}));

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        rv_q[i] <= 1'b0;
      end else if (en_i) begin
        rv_q[i] <= cv;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (cy >= 0) begin
          rx_q[i] <= cx + ys;
          ry_q[i] <= cy - xs;
          rz_q[i] <= cz + step;
        end else begin
          rx_q[i] <= cx - ys;
          ry_q[i] <= cy + xs;
          rz_q[i] <= cz - step;
        end
        rs_q[i] <= cs;
      end
    end
  end

  assign valid_o = rv_q[CORDIC_STEPS-1];
  assign z_o     = rz_q[CORDIC_STEPS-1];
  assign side_o  = rs_q[CORDIC_STEPS-1];

endmodule

// ===== rtl/fbik_solver.sv =====
// ----------------------------------------------------------------------------
// fbik_solver
// one motor: discriminant, square root, half-angle arctangent, rounding
// ----------------------------------------------------------------------------
module fbik_solver #(
  parameter int   ANGLE_FRAC_BITS = 16,
  parameter logic PLUS            = 1'b1
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               en_i,
  input  logic                               valid_i,
  input  logic signed [fbik_pkg::OFF_W-1:0]   u_i,
  input  logic signed [fbik_pkg::COORD_W-1:0] y_i,
  input  logic [fbik_pkg::LEN_W-1:0]          la_i,
  input  logic [fbik_pkg::LEN_W-1:0]          lb_i,
  output logic                               valid_o,
  output logic signed [ANGLE_FRAC_BITS+2:0]  angle_o,
  output fbik_pkg::solve_flags_t             flags_o
);
  import fbik_pkg::*;

  localparam int ANG_W = ANGLE_FRAC_BITS + 3;
  localparam int SH    = 30 - ANGLE_FRAC_BITS;
  localparam int RQ_W  = Z_W + 1;
  localparam logic [63:0] PI_RND = (64'(PI_Q30) + (64'd1 << (SH - 1))) >> SH;
  localparam logic signed [RQ_W-1:0] PI_OUT = RQ_W'(PI_RND);

  logic [6:0] v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[5:0], valid_i};
    end
  end

  // s1: squares and cross products
  logic signed [LEN_W:0]   la_s, lb_s, dif;
  logic [LEN_W:0]          sum;
  logic signed [49:0]      uu_p;
  logic signed [47:0]      yy_p, dif2_p, lay_p;
  logic signed [48:0]      lau_p;
  logic [47:0]             sum2_p;
  logic [45:0]             la2_p, lb2_p;

  logic [48:0]             uu_q;
  logic [46:0]             yy_q, dif2_q;
  logic [47:0]             sum2_q;
  logic [45:0]             la2_q, lb2_q;
  logic signed [LAY_W-1:0] lay2_1_q;
  logic signed [49:0]      lau2_q;

  always_comb begin
    la_s   = $signed({1'b0, la_i});
    lb_s   = $signed({1'b0, lb_i});
    sum    = {1'b0, la_i} + {1'b0, lb_i};
    dif    = la_s - lb_s;
    uu_p   = u_i * u_i;
    yy_p   = y_i * y_i;
    sum2_p = sum * sum;
    dif2_p = dif * dif;
    la2_p  = la_i * la_i;
    lb2_p  = lb_i * lb_i;
    lay_p  = la_s * y_i;
    lau_p  = la_s * u_i;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      uu_q     <= uu_p[48:0];
      yy_q     <= yy_p[46:0];
      sum2_q   <= sum2_p;
      dif2_q   <= dif2_p[46:0];
      la2_q    <= la2_p;
      lb2_q    <= lb2_p;
      lay2_1_q <= {lay_p, 1'b0};
      lau2_q   <= {lau_p, 1'b0};
    end
  end

  // s2: radius squared and the rest of the denominator
  logic [48:0]              r2_q;
  logic signed [WIDE_W-1:0] gsum_q;
  logic [47:0]              sum2_2_q;
  logic [46:0]              dif2_2_q;
  logic signed [LAY_W-1:0]  lay2_2_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r2_q     <= 49'(uu_q) + 49'(yy_q);
      gsum_q   <= WIDE_W'($signed({1'b0, la2_q})) - WIDE_W'($signed({1'b0, lb2_q}))
                  + WIDE_W'(lau2_q);
      sum2_2_q <= sum2_q;
      dif2_2_q <= dif2_q;
      lay2_2_q <= lay2_1_q;
    end
  end

  // s3: discriminant factors and denominator
  logic signed [WIDE_W-1:0] fa_q, fb_q, den3_q;
  logic signed [LAY_W-1:0]  lay2_3_q;
  logic signed [WIDE_W-1:0] r2_s;

  assign r2_s = WIDE_W'($signed({1'b0, r2_q}));

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      fa_q     <= WIDE_W'($signed({1'b0, sum2_2_q})) - r2_s;
      fb_q     <= r2_s - WIDE_W'($signed({1'b0, dif2_2_q}));
      den3_q   <= gsum_q + r2_s;
      lay2_3_q <= lay2_2_q;
    end
  end

  // s4: sign tests and magnitudes
  logic [MAG_W-1:0]         ma_q, mb_q;
  logic                     ok4_q, ws4_q;
  logic signed [WIDE_W-1:0] den4_q;
  logic signed [LAY_W-1:0]  lay2_4_q;
  logic                     a_nn, b_nn;

  assign a_nn = (fa_q >= 0);
  assign b_nn = (fb_q >= 0);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ma_q     <= MAG_W'(a_nn ? fa_q : -fa_q);
      mb_q     <= MAG_W'(b_nn ? fb_q : -fb_q);
      ok4_q    <= (a_nn && b_nn) || (fa_q == 0) || (fb_q == 0);
      ws4_q    <= a_nn && b_nn;
      den4_q   <= den3_q;
      lay2_4_q <= lay2_3_q;
    end
  end

  // s5: partial products of the wide product
  logic [MAG_W-1:0] pp_ll_q, pp_lh_q, pp_hl_q, pp_hh_q;
  sq_side_t         side5_q, side6_q, side7_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pp_ll_q <= ma_q[HALF_W-1:0] * mb_q[HALF_W-1:0];
      pp_lh_q <= ma_q[HALF_W-1:0] * mb_q[MAG_W-1:HALF_W];
      pp_hl_q <= ma_q[MAG_W-1:HALF_W] * mb_q[HALF_W-1:0];
      pp_hh_q <= ma_q[MAG_W-1:HALF_W] * mb_q[MAG_W-1:HALF_W];
      side5_q <= '{den: den4_q, lay2: lay2_4_q, ok: ok4_q, ws: ws4_q};
    end
  end

  // s6/s7: sum the partial products
  logic [MAG_W:0]   mid_q;
  logic [RAD_W-1:0] cat_q, prod_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mid_q   <= (MAG_W+1)'(pp_lh_q) + (MAG_W+1)'(pp_hl_q);
      cat_q   <= {pp_hh_q, pp_ll_q};
      side6_q <= side5_q;
      prod_q  <= cat_q + (RAD_W'(mid_q) << HALF_W);
      side7_q <= side6_q;
    end
  end

  // square root of the discriminant
  logic              sq_v;
  logic [ROOT_W-1:0] sq_root;
  sq_side_t          sq_side;

  fbik_isqrt #(
    .RAD_W  (RAD_W),
    .SIDE_W ($bits(sq_side_t))
  ) u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en_i),
    .valid_i (v_q[6]),
    .rad_i   (prod_q),
    .side_i  (side7_q),
    .valid_o (sq_v),
    .root_o  (sq_root),
    .side_o  (sq_side)
  );

  // numerator
  logic signed [WIDE_W-1:0] num_q, dnn_q;
  logic                     okn_q, wsn_q, vn_q;
  logic signed [WIDE_W-1:0] root_s;

  assign root_s = WIDE_W'($signed({1'b0, sq_root}));

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_q <= PLUS ? (WIDE_W'(sq_side.lay2) + root_s) : (WIDE_W'(sq_side.lay2) - root_s);
      dnn_q <= sq_side.den;
      okn_q <= sq_side.ok;
      wsn_q <= sq_side.ws;
    end
  end

  // fold the sign of the denominator into the pair
  logic signed [WIDE_W-1:0] cden_q, cnum_q;
  cd_side_t                 cside_q;
  logic                     vf_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cden_q  <= (dnn_q < 0) ? -dnn_q : dnn_q;
      cnum_q  <= (dnn_q < 0) ? -num_q : num_q;
      cside_q <= '{dz: (dnn_q == 0), npos: (num_q > 0), nzero: (num_q == 0),
                   ok: okn_q, ws: wsn_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vn_q <= 1'b0;
      vf_q <= 1'b0;
    end else if (en_i) begin
      vn_q <= sq_v;
      vf_q <= vn_q;
    end
  end

  logic                  cd_v;
  logic signed [Z_W-1:0] cd_z;
  cd_side_t              cd_side;

  fbik_cordic #(
    .SIDE_W ($bits(cd_side_t))
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en_i),
    .valid_i (vf_q),
    .den_i   (cden_q),
    .num_i   (cnum_q),
    .side_i  (cside_q),
    .valid_o (cd_v),
    .z_o     (cd_z),
    .side_o  (cd_side)
  );

  // double, round, clamp, and the zero denominator cases
  logic signed [RQ_W-1:0]  rsum, rq, rclamp;
  logic signed [ANG_W-1:0] ang_d, ang_q;
  solve_flags_t            flg_d, flg_q;
  logic                    vr_q;

  always_comb begin
    rsum   = {cd_z, 1'b0} + RQ_W'(64'd1 << (SH - 1));
    rq     = rsum >>> SH;
    rclamp = rq;
    if (rq > PI_OUT) begin
      rclamp = PI_OUT;
    end else if (rq < -PI_OUT) begin
      rclamp = -PI_OUT;
    end
    ang_d = ANG_W'(rclamp);
    if (cd_side.dz) begin
      ang_d = cd_side.npos ? ANG_W'(PI_OUT) : ANG_W'(-PI_OUT);
    end
    flg_d.ok = cd_side.ok && !(cd_side.dz && cd_side.nzero);
    flg_d.ws = cd_side.ws;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vr_q <= 1'b0;
    end else if (en_i) begin
      vr_q <= cd_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ang_q <= ang_d;
      flg_q <= flg_d;
    end
  end

  assign valid_o = vr_q;
  assign angle_o = ang_q;
  assign flags_o = flg_q;

endmodule
